/* sv/swik_pkg.sv */
package swik_pkg;

   localparam int NUM_WHEELS = 2;
   localparam int WHEEL_W    = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

   localparam int CMD_W      = 23;
   localparam int POS_W      = 19;
   localparam int SCALE_W    = 32;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 88;

   localparam int VEL_W      = 27;
   localparam int SQ_W       = 54;
   localparam int RAD_W      = 52;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 4;
   localparam int CX_W       = 48;
   localparam int CZ_W       = 28;
   localparam int ANGLE_W    = 18;
   localparam int SPEED_W    = 25;
   localparam int RPM_W      = 43;
   localparam int PROD_W     = SPEED_W + SCALE_W;

   localparam int ITER_STAGES   = ROOT_W / 2;
   localparam int CORDIC_STEPS  = 24;
   localparam int HALF_PI_Q16   = 102944;

   typedef enum logic [2:0] {
      CSR_FRONT_X = 3'd0,
      CSR_FRONT_Y = 3'd1,
      CSR_REAR_X  = 3'd2,
      CSR_REAR_Y  = 3'd3,
      CSR_RPM     = 3'd4
   } csr_index_type;

   localparam logic [1:0] DIR_STOP = 2'b00;
   localparam logic [1:0] DIR_FWD  = 2'b01;
   localparam logic [1:0] DIR_REV  = 2'b11;

   // Arctangent of 2^-i in Q24; entries from index 24 on are zero.
   localparam logic signed [CZ_W-1:0] ATAN_Q24 [32] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
      28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
      28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
      28'sd256,      28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2,
      28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0
   };

   typedef struct packed {
      logic [WHEEL_W-1:0]      wheel;
      logic                    last;
      logic                    stop;
      logic                    wx_zero;
      logic                    wy_zero;
      logic                    neg;
      logic                    wy_neg;
      logic [RAD_W-1:0]        rad;
      logic [REM_W-1:0]        rem;
      logic [ROOT_W-1:0]       root;
      logic signed [CX_W-1:0]  cx;
      logic signed [CX_W-1:0]  cy;
      logic signed [CZ_W-1:0]  cz;
   } swik_iter_type;

endpackage

/* sv/swik_iter_pipe.sv */
module swik_iter_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  swik_pkg::swik_iter_type in_data,
   output logic                   out_valid,
   output swik_pkg::swik_iter_type out_data
);
   import swik_pkg::*;

   swik_iter_type             stg_ff [ITER_STAGES];
   swik_iter_type             stg_in [ITER_STAGES];
   swik_iter_type             src    [ITER_STAGES];
   logic [ITER_STAGES-1:0]    v_ff;
   logic [ITER_STAGES-1:0]    src_v;

   // Each stage takes two square-root digits and two CORDIC rotations.
   for (genvar k = 0; k < ITER_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src[k]   = in_data;
         assign src_v[k] = in_valid;
      end else begin : g_next
         assign src[k]   = stg_ff[k-1];
         assign src_v[k] = v_ff[k-1];
      end

      always_comb begin
         swik_iter_type          cur;
         logic [REM_W-1:0]       rem_n;
         logic [REM_W-1:0]       trial;
         logic signed [CX_W-1:0] xs;
         logic signed [CX_W-1:0] ys;
         cur = src[k];
         for (int j = 0; j < 2; j++) begin
            rem_n = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
            trial = {2'b00, cur.root, 2'b01};
            if (rem_n >= trial) begin
               cur.rem  = rem_n - trial;
               cur.root = {cur.root[ROOT_W-2:0], 1'b1};
            end else begin
               cur.rem  = rem_n;
               cur.root = {cur.root[ROOT_W-2:0], 1'b0};
            end
            cur.rad = {cur.rad[RAD_W-3:0], 2'b00};

            xs = cur.cx >>> (2 * k + j);
            ys = cur.cy >>> (2 * k + j);
            if (!cur.cy[CX_W-1]) begin
               cur.cx = cur.cx + ys;
               cur.cy = cur.cy - xs;
               cur.cz = cur.cz + ATAN_Q24[5'(2 * k + j)];
            end else begin
               cur.cx = cur.cx - ys;
               cur.cy = cur.cy + xs;
               cur.cz = cur.cz - ATAN_Q24[5'(2 * k + j)];
            end
         end
         stg_in[k] = cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= src_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign out_valid = v_ff[ITER_STAGES-1];
   assign out_data  = stg_ff[ITER_STAGES-1];

endmodule

/* sv/swerve_wheel_inverse_kinematics.sv */
// Each command is held while its wheels are issued, one wheel per cycle while
// the output is not stalled, into a single pipelined square-root and CORDIC
// datapath of 13 stages. Each command yields one result per wheel, and a new
// command can be taken as its last wheel issues, before its results leave.
// Reset: synchronous, active high; clears all valid bits, the wheel counter
// and the configuration registers (positions and rpm scale become zero).
module swerve_wheel_inverse_kinematics (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // body_vx [22:0], body_vy [45:23], body_omega [68:46], zeros above
   input  logic [swik_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // steer_angle [17:0], ground_speed [42:18], drive_direction [44:43],
   // motor_rpm [87:45]
   output logic [swik_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // wheel_index [0]
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [31:0]                       csr_data
);
   import swik_pkg::*;

   // The whole pipeline moves as one: it advances whenever the output
   // register is empty or its item is being taken.
   logic adv;

   // Configuration registers.
   logic signed [POS_W-1:0] front_x_ff, front_y_ff, rear_x_ff, rear_y_ff;
   logic [SCALE_W-1:0]      rpm_scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_x_ff   <= '0;
         front_y_ff   <= '0;
         rear_x_ff    <= '0;
         rear_y_ff    <= '0;
         rpm_scale_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRONT_X: front_x_ff   <= csr_data[POS_W-1:0];
            CSR_FRONT_Y: front_y_ff   <= csr_data[POS_W-1:0];
            CSR_REAR_X:  rear_x_ff    <= csr_data[POS_W-1:0];
            CSR_REAR_Y:  rear_y_ff    <= csr_data[POS_W-1:0];
            CSR_RPM:     rpm_scale_ff <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Command holding register. The command stays while its wheels are issued
   // one per cycle when adv is set; a new one is taken as the last wheel leaves.
   logic signed [CMD_W-1:0] cmd_vx_ff, cmd_vy_ff, cmd_om_ff;
   logic                    cmd_valid_ff;
   logic [WHEEL_W-1:0]      wheel_ff;
   logic                    last_issue;
   logic                    issue_done;

   assign last_issue = (wheel_ff == WHEEL_W'(NUM_WHEELS - 1));
   assign issue_done = adv && cmd_valid_ff && last_issue;
   assign req_tready = !cmd_valid_ff || issue_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         wheel_ff     <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            cmd_valid_ff <= 1'b1;
         end else if (issue_done) begin
            cmd_valid_ff <= 1'b0;
         end
         if (adv && cmd_valid_ff) begin
            wheel_ff <= last_issue ? '0 : wheel_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_vx_ff <= req_tdata[22:0];
         cmd_vy_ff <= req_tdata[45:23];
         cmd_om_ff <= req_tdata[68:46];
      end
   end

   // Stage 1: yaw-rate products with the selected wheel position. Any wheel
   // beyond the second sits at the body centre.
   logic signed [POS_W-1:0]         pos_x, pos_y;
   logic                            s1_v_ff, s1_last_ff;
   logic [WHEEL_W-1:0]              s1_wheel_ff;
   logic signed [CMD_W-1:0]         s1_vx_ff, s1_vy_ff;
   logic signed [CMD_W+POS_W-1:0]   s1_px_ff, s1_py_ff;

   always_comb begin
      if (wheel_ff == WHEEL_W'(0)) begin
         pos_x = front_x_ff;
         pos_y = front_y_ff;
      end else if (wheel_ff == WHEEL_W'(1)) begin
         pos_x = rear_x_ff;
         pos_y = rear_y_ff;
      end else begin
         pos_x = '0;
         pos_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_wheel_ff <= wheel_ff;
         s1_last_ff  <= last_issue;
         s1_vx_ff    <= cmd_vx_ff;
         s1_vy_ff    <= cmd_vy_ff;
         s1_px_ff    <= (CMD_W+POS_W)'(cmd_om_ff) * (CMD_W+POS_W)'(pos_x);
         s1_py_ff    <= (CMD_W+POS_W)'(cmd_om_ff) * (CMD_W+POS_W)'(pos_y);
      end
   end

   // Stage 2: round the products to Q16 and form the wheel velocity.
   localparam int RND_W = CMD_W + POS_W + 1;
   logic                    s2_v_ff, s2_last_ff;
   logic [WHEEL_W-1:0]      s2_wheel_ff;
   logic signed [VEL_W-1:0] s2_wx_ff, s2_wy_ff;
   logic signed [RND_W-1:0] rnd_x, rnd_y;

   assign rnd_x = (RND_W'(s1_px_ff) + RND_W'(32768)) >>> 16;
   assign rnd_y = (RND_W'(s1_py_ff) + RND_W'(32768)) >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_wheel_ff <= s1_wheel_ff;
         s2_last_ff  <= s1_last_ff;
         s2_wx_ff    <= VEL_W'(s1_vx_ff) - VEL_W'(rnd_y);
         s2_wy_ff    <= VEL_W'(s1_vy_ff) + VEL_W'(rnd_x);
      end
   end

   // Stage 3: squares for the magnitude, and the fold into the right half
   // plane that flips the drive direction.
   logic                    s3_v_ff, s3_last_ff;
   logic [WHEEL_W-1:0]      s3_wheel_ff;
   logic [SQ_W-1:0]         s3_sqx_ff, s3_sqy_ff;
   logic [VEL_W-1:0]        s3_ax_ff, s3_ay_ff;
   logic                    s3_stop_ff, s3_wx0_ff, s3_wy0_ff, s3_neg_ff, s3_wyneg_ff;
   logic signed [VEL_W-1:0] fold_x, fold_y;
   logic                    fold_neg;

   assign fold_neg = s2_wx_ff[VEL_W-1];
   assign fold_x   = fold_neg ? -s2_wx_ff : s2_wx_ff;
   assign fold_y   = fold_neg ? -s2_wy_ff : s2_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_wheel_ff <= s2_wheel_ff;
         s3_last_ff  <= s2_last_ff;
         s3_sqx_ff   <= SQ_W'(SQ_W'(s2_wx_ff) * SQ_W'(s2_wx_ff));
         s3_sqy_ff   <= SQ_W'(SQ_W'(s2_wy_ff) * SQ_W'(s2_wy_ff));
         s3_ax_ff    <= fold_x;
         s3_ay_ff    <= fold_y[VEL_W-1] ? -fold_y : fold_y;
         s3_stop_ff  <= (s2_wx_ff == '0) && (s2_wy_ff == '0);
         s3_wx0_ff   <= (s2_wx_ff == '0);
         s3_wy0_ff   <= (s2_wy_ff == '0);
         s3_neg_ff   <= fold_neg;
         s3_wyneg_ff <= fold_y[VEL_W-1];
      end
   end

   // Stage 4: sum of squares and CORDIC operands scaled by 2^20.
   logic          s4_v_ff;
   swik_iter_type s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_ff.wheel   <= s3_wheel_ff;
         s4_ff.last    <= s3_last_ff;
         s4_ff.stop    <= s3_stop_ff;
         s4_ff.wx_zero <= s3_wx0_ff;
         s4_ff.wy_zero <= s3_wy0_ff;
         s4_ff.neg     <= s3_neg_ff;
         s4_ff.wy_neg  <= s3_wyneg_ff;
         s4_ff.rad     <= RAD_W'(s3_sqx_ff + s3_sqy_ff);
         s4_ff.rem     <= '0;
         s4_ff.root    <= '0;
         s4_ff.cx      <= CX_W'(s3_ax_ff) << 20;
         s4_ff.cy      <= CX_W'(s3_ay_ff) << 20;
         s4_ff.cz      <= '0;
      end
   end

   // Stages 5 to 17: square root and CORDIC side by side.
   logic          it_v;
   swik_iter_type it_d;

   swik_iter_pipe u_iter (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s4_v_ff),
      .in_data   (s4_ff),
      .out_valid (it_v),
      .out_data  (it_d)
   );

   // Output register: angle rounding, clamping and sign, plus the rpm product.
   logic signed [CZ_W-1:0]    z_rnd;
   logic [ANGLE_W-1:0]        ang_mag;
   logic [ANGLE_W-1:0]        ang_sel;
   logic                      rsp_v_ff, out_last_ff;
   logic [WHEEL_W-1:0]        out_wheel_ff;
   logic [ANGLE_W-1:0]        out_ang_ff;
   logic [SPEED_W-1:0]        out_spd_ff;
   logic [1:0]                out_dir_ff;
   logic [PROD_W-1:0]         out_prod_ff;

   assign z_rnd = (it_d.cz + CZ_W'(128)) >>> 8;

   always_comb begin
      if (z_rnd[CZ_W-1]) begin
         ang_mag = '0;
      end else if (z_rnd > CZ_W'(HALF_PI_Q16)) begin
         ang_mag = ANGLE_W'(HALF_PI_Q16);
      end else begin
         ang_mag = z_rnd[ANGLE_W-1:0];
      end
      if (it_d.wy_zero) begin
         ang_sel = '0;
      end else if (it_d.wx_zero) begin
         ang_sel = ANGLE_W'(HALF_PI_Q16);
      end else begin
         ang_sel = ang_mag;
      end
   end

   assign adv = !rsp_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= it_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_wheel_ff <= it_d.wheel;
         out_last_ff  <= it_d.last;
         out_ang_ff   <= it_d.wy_neg ? -ang_sel : ang_sel;
         out_spd_ff   <= it_d.root[SPEED_W-1:0];
         out_prod_ff  <= PROD_W'(it_d.root[SPEED_W-1:0]) * PROD_W'(rpm_scale_ff);
         if (it_d.stop) begin
            out_dir_ff <= DIR_STOP;
         end else if (it_d.neg) begin
            out_dir_ff <= DIR_REV;
         end else begin
            out_dir_ff <= DIR_FWD;
         end
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_wheel_ff[0];
   assign rsp_tdata  = {RPM_W'(out_prod_ff[PROD_W-1:16]), out_dir_ff, out_spd_ff,
                        out_ang_ff};

   // A stopped wheel and only a stopped wheel reports zero speed.
   a_stop_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> ((out_dir_ff == DIR_STOP) == (out_spd_ff == '0)))
      else $error("drive direction and wheel speed disagree on a stopped wheel");

   // The steering angle never leaves the folded half plane.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (($signed(out_ang_ff) <= $signed(ANGLE_W'(HALF_PI_Q16))) &&
                    ($signed(out_ang_ff) >= -$signed(ANGLE_W'(HALF_PI_Q16)))))
      else $error("steering angle outside plus or minus pi/2");

   // The last-wheel flag follows the wheel number through the pipeline.
   a_last_wheel: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (out_last_ff == (out_wheel_ff == WHEEL_W'(NUM_WHEELS - 1))))
      else $error("last-wheel flag does not match wheel number");

   // No new command is taken while a held one is still issuing wheels.
   a_hold_cmd: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid_ff && !issue_done) |-> !req_tready)
      else $error("command accepted while the previous one is still issuing");

endmodule
